@@ src/pixel_gamma_white_balance_top_assert.svh @@
// Assertion macros used by the pixel gamma and white balance top level.
`ifndef PIXEL_GAMMA_WHITE_BALANCE_TOP_ASSERT_SVH
`define PIXEL_GAMMA_WHITE_BALANCE_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PGWB_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("pgwb: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define PGWB_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("pgwb: next-cycle check failed");

`endif

@@ src/pgwb_pkg.sv @@
// Shared types, constants and elaboration-time functions of the pixel gamma block.
package pgwb_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SET_W    = 7;
  localparam int FRAC_W   = 20;
  localparam int LOG_W    = 24;
  localparam int DIV_W    = 30;
  localparam int SHIFT_W  = 11;
  localparam int PROD_W   = 23;

  localparam logic [SET_W-1:0]    GAMMA_NEUTRAL = 7'd50;
  localparam logic [SET_W-1:0]    RED_NEUTRAL   = 7'd52;
  localparam logic [SET_W-1:0]    BLUE_NEUTRAL  = 7'd95;
  localparam logic [SAMPLE_W-1:0] FULL_WIDE     = 16'hFFFF;
  localparam logic [SAMPLE_W-1:0] FULL_NARROW   = 16'h00FF;

  localparam int RECIP_SHIFT = 30;
  localparam logic [31:0] RECIP_RED  = 32'((64'd1 << RECIP_SHIFT) / 64'd52);
  localparam logic [31:0] RECIP_BLUE = 32'((64'd1 << RECIP_SHIFT) / 64'd95);

  localparam int LOG_STAGES = FRAC_W;
  localparam int DIV_STAGES = DIV_W;
  localparam int EXP_STAGES = FRAC_W;
  localparam int LANE_LAT   = 1 + LOG_STAGES + 1 + DIV_STAGES + 1 + EXP_STAGES + 2;
  localparam int MERGE_LAT  = 3;
  localparam int TOTAL_LAT  = LANE_LAT + MERGE_LAT;

  typedef enum logic [2:0] {
    REG_GAMMA  = 3'd0,
    REG_RED    = 3'd1,
    REG_BLUE   = 3'd2,
    REG_WIDE   = 3'd3,
    REG_COLOUR = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_red;
    logic [SAMPLE_W-1:0] sample_green;
    logic [SAMPLE_W-1:0] sample_blue;
  } pixel_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] result_red;
    logic [SAMPLE_W-1:0] result_green;
    logic [SAMPLE_W-1:0] result_blue;
  } pixel_out_t;

  typedef struct packed {
    logic [SET_W-1:0] gamma;
    logic [SET_W-1:0] red;
    logic [SET_W-1:0] blue;
    logic             wide;
    logic             colour;
  } cfg_t;

  typedef struct packed {
    logic                valid;
    logic [SAMPLE_W-1:0] value;
  } lane_out_t;

  // Integer square root, used only to build constants.
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] rem;
    r   = '0;
    b   = 64'd1 << 62;
    rem = v;
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (rem >= r + b) begin
          rem = rem - (r + b);
          r   = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // Q30 value of 2^(2^-k).
  function automatic logic [63:0] root_q30(input int k);
    logic [63:0] r;
    r = 64'd1 << 31;
    for (int j = 1; j <= k; j++) begin
      r = isqrt64(r << 30);
    end
    return r;
  endfunction

  // log2 in Q20 by repeated squaring, used only for full-scale constants.
  function automatic logic [63:0] log2_q20(input logic [31:0] v);
    int          p;
    logic [63:0] m;
    logic [63:0] frac;
    p = 0;
    for (int i = 1; i < 32; i++) begin
      if ((v >> i) != 0) p = i;
    end
    m    = {32'd0, v} << (30 - p);
    frac = '0;
    for (int i = 0; i < FRAC_W; i++) begin
      m    = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        frac = frac | 64'd1;
        m    = m >> 1;
      end
    end
    return (64'(p) << FRAC_W) | frac;
  endfunction

  localparam logic [LOG_W-1:0] LOG_FULL_WIDE   = LOG_W'(log2_q20(32'd65535));
  localparam logic [LOG_W-1:0] LOG_FULL_NARROW = LOG_W'(log2_q20(32'd255));

endpackage

@@ src/pgwb_lane.sv @@
// One gamma lane: log2, scaled exponent division, exp2 by root products, rescale.
module pgwb_lane (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic [pgwb_pkg::SAMPLE_W-1:0]    in_sample,
  input  pgwb_pkg::cfg_t                   cfg,
  output pgwb_pkg::lane_out_t              lane_out
);

  localparam int LAT = pgwb_pkg::LANE_LAT;
  localparam int SW  = pgwb_pkg::SAMPLE_W;
  localparam int FW  = pgwb_pkg::FRAC_W;
  localparam int DW  = pgwb_pkg::DIV_W;
  localparam int HW  = pgwb_pkg::SHIFT_W;

  logic [SW-1:0] full;
  assign full = cfg.wide ? pgwb_pkg::FULL_WIDE : pgwb_pkg::FULL_NARROW;

  // Valid track.
  logic [LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // Normalise: leading one index and Q30 mantissa.
  logic [SW-1:0] xm;
  logic [3:0]    lead;
  assign xm = in_sample & full;
  always_comb begin
    lead = '0;
    for (int i = 1; i < SW; i++) begin
      if (xm[i]) lead = 4'(i);
    end
  end

  logic [SW-1:0] lx_r [0:pgwb_pkg::LOG_STAGES];
  logic [3:0]    lp_r [0:pgwb_pkg::LOG_STAGES];
  logic [31:0]   lm_r [0:pgwb_pkg::LOG_STAGES];
  logic [FW-1:0] lf_r [0:pgwb_pkg::LOG_STAGES];

  always_ff @(posedge clk) begin
    lx_r[0] <= xm;
    lp_r[0] <= lead;
    lm_r[0] <= {16'd0, xm} << (5'd30 - {1'b0, lead});
    lf_r[0] <= '0;
  end

  // One squaring per stage yields one fraction bit.
  for (genvar j = 1; j <= pgwb_pkg::LOG_STAGES; j++) begin : g_log
    logic [63:0] sq;
    logic [31:0] t;
    assign sq = {32'd0, lm_r[j-1]} * {32'd0, lm_r[j-1]};
    assign t  = sq[61:30];
    always_ff @(posedge clk) begin
      lx_r[j] <= lx_r[j-1];
      lp_r[j] <= lp_r[j-1];
      lm_r[j] <= t[31] ? (t >> 1) : t;
      lf_r[j] <= {lf_r[j-1][FW-2:0], t[31]};
    end
  end

  // Distance below full scale, times the neutral setting.
  logic [pgwb_pkg::LOG_W-1:0] lfull;
  logic [pgwb_pkg::LOG_W-1:0] log_gap;
  assign lfull   = cfg.wide ? pgwb_pkg::LOG_FULL_WIDE : pgwb_pkg::LOG_FULL_NARROW;
  assign log_gap = lfull - {lp_r[pgwb_pkg::LOG_STAGES], lf_r[pgwb_pkg::LOG_STAGES]};

  logic [DW-1:0] dq_r   [0:pgwb_pkg::DIV_STAGES];
  logic [DW-1:0] dn_r   [0:pgwb_pkg::DIV_STAGES];
  logic [6:0]    drem_r [0:pgwb_pkg::DIV_STAGES];
  logic [SW-1:0] dx_r   [0:pgwb_pkg::DIV_STAGES];

  always_ff @(posedge clk) begin
    dn_r[0]   <= DW'({6'd0, log_gap} * 30'd50);
    dq_r[0]   <= '0;
    drem_r[0] <= '0;
    dx_r[0]   <= lx_r[pgwb_pkg::LOG_STAGES];
  end

  // Restoring division by the gamma setting, one quotient bit per stage.
  for (genvar i = 1; i <= pgwb_pkg::DIV_STAGES; i++) begin : g_div
    logic [7:0] trial;
    logic       ge;
    assign trial = {drem_r[i-1], dn_r[i-1][DW-1]};
    assign ge    = trial >= {1'b0, cfg.gamma};
    always_ff @(posedge clk) begin
      dn_r[i]   <= {dn_r[i-1][DW-2:0], 1'b0};
      dq_r[i]   <= {dq_r[i-1][DW-2:0], ge};
      drem_r[i] <= ge ? 7'(trial - {1'b0, cfg.gamma}) : trial[6:0];
      dx_r[i]   <= dx_r[i-1];
    end
  end

  // Split into integer shift and fractional exponent.
  logic [DW-1:0] quo;
  logic [FW-1:0] fr;
  logic [FW:0]   hfull;
  assign quo   = dq_r[pgwb_pkg::DIV_STAGES];
  assign fr    = quo[FW-1:0];
  assign hfull = (21'd1 << FW) - {1'b0, fr};

  logic [FW-1:0] eh_r [0:pgwb_pkg::EXP_STAGES];
  logic [31:0]   ev_r [0:pgwb_pkg::EXP_STAGES];
  logic [HW-1:0] es_r [0:pgwb_pkg::EXP_STAGES];
  logic [SW-1:0] ex_r [0:pgwb_pkg::EXP_STAGES];

  always_ff @(posedge clk) begin
    eh_r[0] <= hfull[FW-1:0];
    ev_r[0] <= 32'd1 << 30;
    es_r[0] <= {1'b0, quo[DW-1:FW]} + ((fr == '0) ? 11'd30 : 11'd31);
    ex_r[0] <= dx_r[pgwb_pkg::DIV_STAGES];
  end

  // Multiply in the root 2^(2^-k) where bit (20-k) of the complement is set.
  for (genvar k = 1; k <= pgwb_pkg::EXP_STAGES; k++) begin : g_exp
    localparam logic [31:0] RK = 32'(pgwb_pkg::root_q30(k));
    logic [63:0] pr;
    assign pr = {32'd0, ev_r[k-1]} * {32'd0, RK};
    always_ff @(posedge clk) begin
      eh_r[k] <= eh_r[k-1];
      ev_r[k] <= eh_r[k-1][FW-k] ? pr[61:30] : ev_r[k-1];
      es_r[k] <= es_r[k-1];
      ex_r[k] <= ex_r[k-1];
    end
  end

  // Rescale to full range.
  logic [47:0]   my_r;
  logic [HW-1:0] ms_r;
  logic [SW-1:0] mx_r;
  always_ff @(posedge clk) begin
    my_r <= {32'd0, full} * {16'd0, ev_r[pgwb_pkg::EXP_STAGES]};
    ms_r <= es_r[pgwb_pkg::EXP_STAGES];
    mx_r <= ex_r[pgwb_pkg::EXP_STAGES];
  end

  logic [47:0]   shifted;
  logic [SW-1:0] y;
  logic [SW-1:0] res;
  assign shifted = (ms_r >= 11'd48) ? 48'd0 : (my_r >> ms_r[5:0]);
  assign y       = (shifted > {32'd0, full}) ? full : shifted[SW-1:0];

  // Neutral gamma passes, zero gamma keeps only full scale, zero stays zero.
  always_comb begin
    if (cfg.gamma == pgwb_pkg::GAMMA_NEUTRAL) begin
      res = mx_r;
    end else if (cfg.gamma == '0) begin
      res = (mx_r == full) ? full : '0;
    end else if (mx_r == '0) begin
      res = '0;
    end else begin
      res = y;
    end
  end

  logic [SW-1:0] res_r;
  always_ff @(posedge clk) begin
    res_r <= res;
  end

  assign lane_out.valid = vld_r[LAT-1];
  assign lane_out.value = res_r;

endmodule

@@ src/pgwb_merge.sv @@
// Merge stage: white balance on red and blue, mono masking, output register.
module pgwb_merge (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pgwb_pkg::lane_out_t    red_in,
  input  pgwb_pkg::lane_out_t    green_in,
  input  pgwb_pkg::lane_out_t    blue_in,
  input  pgwb_pkg::cfg_t         cfg,
  output logic                   out_strobe,
  output pgwb_pkg::pixel_out_t   out_data
);

  localparam int SW = pgwb_pkg::SAMPLE_W;
  localparam int PW = pgwb_pkg::PROD_W;
  localparam int RS = pgwb_pkg::RECIP_SHIFT;

  logic [SW-1:0] full;
  assign full = cfg.wide ? pgwb_pkg::FULL_WIDE : pgwb_pkg::FULL_NARROW;

  logic [pgwb_pkg::MERGE_LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[pgwb_pkg::MERGE_LAT-2:0], red_in.valid};
    end
  end

  // Stage A: gain products.
  logic [PW-1:0] pr_a_r, pb_a_r;
  logic [SW-1:0] r_a_r, g_a_r;
  always_ff @(posedge clk) begin
    pr_a_r <= {7'd0, red_in.value} * {16'd0, cfg.red};
    pb_a_r <= {7'd0, blue_in.value} * {16'd0, cfg.blue};
    r_a_r  <= red_in.value;
    g_a_r  <= green_in.value;
  end

  // Stage B: quotient estimate by reciprocal, at most one low.
  logic [55:0]   qr_full, qb_full;
  logic [PW-1:0] pr_b_r, pb_b_r, qr_b_r, qb_b_r;
  logic [SW-1:0] r_b_r, g_b_r;
  assign qr_full = {33'd0, pr_a_r} * {24'd0, pgwb_pkg::RECIP_RED};
  assign qb_full = {33'd0, pb_a_r} * {24'd0, pgwb_pkg::RECIP_BLUE};
  always_ff @(posedge clk) begin
    qr_b_r <= qr_full[RS+PW-1:RS];
    qb_b_r <= qb_full[RS+PW-1:RS];
    pr_b_r <= pr_a_r;
    pb_b_r <= pb_a_r;
    r_b_r  <= r_a_r;
    g_b_r  <= g_a_r;
  end

  // Stage C: correct, saturate, mask for mono.
  logic [PW+6:0] remr, remb;
  logic [PW-1:0] qr, qb;
  logic [SW-1:0] red_g, blue_g;
  assign remr = {7'd0, pr_b_r} - ({7'd0, qr_b_r} * {23'd0, pgwb_pkg::RED_NEUTRAL});
  assign remb = {7'd0, pb_b_r} - ({7'd0, qb_b_r} * {23'd0, pgwb_pkg::BLUE_NEUTRAL});
  assign qr   = (remr >= {23'd0, pgwb_pkg::RED_NEUTRAL})  ? qr_b_r + 1'b1 : qr_b_r;
  assign qb   = (remb >= {23'd0, pgwb_pkg::BLUE_NEUTRAL}) ? qb_b_r + 1'b1 : qb_b_r;
  assign red_g  = (qr > {7'd0, full}) ? full : qr[SW-1:0];
  assign blue_g = (qb > {7'd0, full}) ? full : qb[SW-1:0];

  pgwb_pkg::pixel_out_t out_r;
  always_ff @(posedge clk) begin
    if (cfg.colour) begin
      out_r.result_red   <= red_g;
      out_r.result_green <= g_b_r;
      out_r.result_blue  <= blue_g;
    end else begin
      out_r.result_red   <= r_b_r;
      out_r.result_green <= '0;
      out_r.result_blue  <= '0;
    end
  end

  assign out_strobe = vld_r[pgwb_pkg::MERGE_LAT-1];
  assign out_data   = out_r;

endmodule

@@ src/pixel_gamma_white_balance_top.sv @@
// Top level of the pixel gamma correction and white balance block.
//
// Takes one pixel per clock: a pixel transfers on every rising edge with start
// high (busy is always low), and its corrected result appears on out_data for
// exactly one cycle with out_strobe high, after passing through its channel lane
// and the merge stage. The receiver cannot stall; a result not taken in its
// strobe cycle is gone. Three identical gamma lanes run side by side, one per
// channel; each lane holds 20 log2 squaring stages, 30 restoring division
// stages by the gamma setting and 20 root product stages. The merge stage
// applies the red and blue gains by reciprocal multiply with one correction
// step and masks the mono case.
// Write configuration only while no pixel is in flight.
module pixel_gamma_white_balance_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  pgwb_pkg::pixel_in_t              in_data,
  output logic                             out_strobe,
  output pgwb_pkg::pixel_out_t             out_data,
  input  logic                             cfg_we,
  input  logic [2:0]                       cfg_index,
  input  logic [pgwb_pkg::SET_W-1:0]       cfg_wdata
);

`include "pixel_gamma_white_balance_top_assert.svh"

  localparam int TOTAL = pgwb_pkg::TOTAL_LAT;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers; out-of-range indices drop the write.
  pgwb_pkg::cfg_t cfg_r, cfg_nxt;
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (pgwb_pkg::cfg_reg_t'(cfg_index))
        pgwb_pkg::REG_GAMMA:  cfg_nxt.gamma  = cfg_wdata;
        pgwb_pkg::REG_RED:    cfg_nxt.red    = cfg_wdata;
        pgwb_pkg::REG_BLUE:   cfg_nxt.blue   = cfg_wdata;
        pgwb_pkg::REG_WIDE:   cfg_nxt.wide   = cfg_wdata[0];
        pgwb_pkg::REG_COLOUR: cfg_nxt.colour = cfg_wdata[0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gamma  <= pgwb_pkg::GAMMA_NEUTRAL;
      cfg_r.red    <= pgwb_pkg::RED_NEUTRAL;
      cfg_r.blue   <= pgwb_pkg::BLUE_NEUTRAL;
      cfg_r.wide   <= 1'b0;
      cfg_r.colour <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // One lane per channel.
  pgwb_pkg::lane_out_t lane_red, lane_green, lane_blue;

  pgwb_lane u_lane_red (
    .clk(clk), .rst_n(rst_n), .in_valid(accept),
    .in_sample(in_data.sample_red), .cfg(cfg_r), .lane_out(lane_red)
  );

  pgwb_lane u_lane_green (
    .clk(clk), .rst_n(rst_n), .in_valid(accept),
    .in_sample(in_data.sample_green), .cfg(cfg_r), .lane_out(lane_green)
  );

  pgwb_lane u_lane_blue (
    .clk(clk), .rst_n(rst_n), .in_valid(accept),
    .in_sample(in_data.sample_blue), .cfg(cfg_r), .lane_out(lane_blue)
  );

  // Combine lanes: gains, mono masking, output register.
  pgwb_merge u_merge (
    .clk(clk), .rst_n(rst_n),
    .red_in(lane_red), .green_in(lane_green), .blue_in(lane_blue),
    .cfg(cfg_r), .out_strobe(out_strobe), .out_data(out_data)
  );

  // Terms for the range and write checks below.
  logic mono_quiet, narrow_fits, gamma_wr;
  assign mono_quiet  = (out_data.result_green == '0) && (out_data.result_blue == '0);
  assign narrow_fits = (out_data.result_red[15:8] == '0) &&
                       (out_data.result_green[15:8] == '0) &&
                       (out_data.result_blue[15:8] == '0);
  assign gamma_wr    = cfg_we && (cfg_index == pgwb_pkg::REG_GAMMA);

  // Every strobe traces back to an accepted transfer, and every transfer gives a strobe.
  `PGWB_ASSERT_NOW(a_strobe_from_transfer, out_strobe, $past(accept, TOTAL))
  `PGWB_ASSERT_NOW(a_transfer_gives_strobe, accept, ##TOTAL out_strobe)
  // Mono mode leaves green and blue at zero.
  `PGWB_ASSERT_NOW(a_mono_zero, out_strobe && !cfg_r.colour, mono_quiet)
  // Narrow samples never leave the 8-bit range.
  `PGWB_ASSERT_NOW(a_narrow_range, out_strobe && !cfg_r.wide, narrow_fits)
  // A gamma write lands in the next cycle.
  `PGWB_ASSERT_NEXT(a_gamma_write, gamma_wr, cfg_r.gamma == $past(cfg_wdata))

endmodule
